@@ rtl/gdn_pkg.sv @@
// gdn_pkg: shared widths, calendar constants and month tables for the date to day number block
`default_nettype none
package gdn_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DN_W    = 22;
    localparam int WD_W    = 3;
    localparam int MLEN_W  = 5;
    localparam int CENT_W  = 8;
    localparam int MOFF_W  = 9;

    localparam logic [YEAR_W-1:0] BASE_YEAR  = 14'd1900;
    localparam logic [YEAR_W-1:0] FIRST_YEAR = 14'd1901;
    localparam logic [YEAR_W-1:0] LAST_YEAR  = 14'd9999;
    localparam logic [DN_W-1:0]   DAY_OFFSET = 22'd49;

    // year / 100 as (year * 5243) >> 19, exact for all 14-bit years
    localparam int                DIV100_SHIFT = 19;
    localparam logic [12:0]       DIV100_MUL   = 13'd5243;
    localparam int                PROD_W       = YEAR_W + 13;
    localparam logic [10:0]       DAYS_4Y      = 11'd1461;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [MONTH_W-1:0] MONTHS_YEAR = 4'd12;

    // days in month, february follows the leap flag
    function automatic logic [MLEN_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
        logic [MLEN_W-1:0] d;
        begin
            if (month == MONTH_FEB) begin
                d = leap ? 5'd29 : 5'd28;
            end else if (month == MONTH_APR || month == MONTH_JUN ||
                         month == MONTH_SEP || month == MONTH_NOV) begin
                d = 5'd30;
            end else begin
                d = 5'd31;
            end
            return d;
        end
    endfunction

    // floor(306 * (m + 1) / 10) for shifted months 3 .. 14
    function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] ms);
        logic [MOFF_W-1:0] o;
        begin
            unique case (ms)
                4'd3:    o = 9'd122;
                4'd4:    o = 9'd153;
                4'd5:    o = 9'd183;
                4'd6:    o = 9'd214;
                4'd7:    o = 9'd244;
                4'd8:    o = 9'd275;
                4'd9:    o = 9'd306;
                4'd10:   o = 9'd336;
                4'd11:   o = 9'd367;
                4'd12:   o = 9'd397;
                4'd13:   o = 9'd428;
                4'd14:   o = 9'd459;
                default: o = 9'd0;
            endcase
            return o;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/gdn_in_if.sv @@
// gdn_in_if: input channel carrying one calendar date per beat
`default_nettype none
interface gdn_in_if;
    logic                           valid;
    logic                           ready;
    logic [gdn_pkg::YEAR_W-1:0]     year;
    logic [gdn_pkg::MONTH_W-1:0]    month;
    logic [gdn_pkg::DAY_W-1:0]      day_of_month;

    modport source (output valid, output year, output month, output day_of_month,
                    input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/gdn_out_if.sv @@
// gdn_out_if: result channel carrying day number, weekday and month length per beat
`default_nettype none
interface gdn_out_if;
    logic                           valid;
    logic                           ready;
    logic                           valid_res;
    logic                           leap;
    logic [gdn_pkg::DN_W-1:0]       day_number;
    logic [gdn_pkg::WD_W-1:0]       weekday;
    logic [gdn_pkg::MLEN_W-1:0]     month_length;

    modport source (output valid, output valid_res, output leap, output day_number,
                    output weekday, output month_length, input ready);
    modport sink   (input valid, input valid_res, input leap, input day_number,
                    input weekday, input month_length, output ready);
endinterface
`default_nettype wire

@@ rtl/gdn_mod7.sv @@
// gdn_mod7: remainder modulo 7 of a day count by folding octal digits
`default_nettype none
module gdn_mod7 (
    input  wire logic [gdn_pkg::DN_W:0]     i_value,
    output      logic [gdn_pkg::WD_W-1:0]   o_rem
);
    import gdn_pkg::*;

    localparam int GROUPS = (DN_W + 1 + 2) / 3;

    logic [3*GROUPS-1:0] padded;
    logic [5:0]          digit_sum;
    logic [3:0]          fold1;
    logic [3:0]          fold2;

    // 8 == 1 mod 7, so octal digits can simply be added
    always_comb begin
        padded    = (3*GROUPS)'(i_value);
        digit_sum = '0;
        for (int g = 0; g < GROUPS; g++) begin
            digit_sum = digit_sum + 6'(padded[3*g +: 3]);
        end
        fold1 = 4'(digit_sum[5:3]) + 4'(digit_sum[2:0]);
        fold2 = 4'(fold1[3]) + 4'(fold1[2:0]);
        if (fold2 >= 4'd7) begin
            o_rem = 3'(fold2 - 4'd7);
        end else begin
            o_rem = fold2[2:0];
        end
    end

endmodule
`default_nettype wire

@@ rtl/gregorian_date_to_day_number.sv @@
// gregorian_date_to_day_number: four-stage pipeline from a calendar date to its day number
//
// i_date takes one date (year, month, day_of_month) per beat; o_res returns one result
// beat per date, in order: valid_res, leap, day_number (days since 1 Jan 1900),
// weekday (0 = Sunday) and month_length. Invalid dates give zero numeric fields.
// A date is accepted into stage 1 and its result shows on o_res once it has passed
// through stage 4. Throughput is one date per cycle while o_res is not stalled;
// the four register stages (shifted year and divide-by-100 products, century and
// year-term multiply, day sum, weekday fold) all move together on one enable.
// When o_res is stalled with a result waiting, the whole pipeline holds and
// i_date.ready drops; empty stages do not fill in while stalled, so nothing is
// lost or repeated. Reset clears the stage valid bits only; after reset the
// block is empty and ready.
`default_nettype none
module gregorian_date_to_day_number (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gdn_in_if.sink      i_date,
    gdn_out_if.source   o_res
);
    import gdn_pkg::*;

    logic advance;

    // stage 1
    logic                   r1_v;
    logic [YEAR_W-1:0]      r1_year;
    logic [MONTH_W-1:0]     r1_month;
    logic [DAY_W-1:0]       r1_day;
    logic [YEAR_W-1:0]      r1_ys;
    logic [MONTH_W-1:0]     r1_ms;
    logic [PROD_W-1:0]      r1_yq;
    logic [PROD_W-1:0]      r1_ysq;
    logic                   n1_early;
    logic [YEAR_W-1:0]      n1_ys;
    logic [MONTH_W-1:0]     n1_ms;

    // stage 2
    logic                   r2_v;
    logic                   r2_ok;
    logic                   r2_leap;
    logic [MLEN_W-1:0]      r2_mlen;
    logic [DN_W-1:0]        r2_yterm;
    logic [MOFF_W-1:0]      r2_moff;
    logic [DAY_W-1:0]       r2_day;
    logic [CENT_W-1:0]      r2_corr;
    logic [CENT_W-1:0]      n2_qy;
    logic [CENT_W-1:0]      n2_cent;
    logic                   n2_leap;
    logic [MLEN_W-1:0]      n2_mlen;
    logic                   n2_ok;
    logic [YEAR_W-1:0]      n2_yoff;
    logic [24:0]            n2_yprod;

    // stage 3
    logic                   r3_v;
    logic                   r3_ok;
    logic                   r3_leap;
    logic [MLEN_W-1:0]      r3_mlen;
    logic [DN_W-1:0]        r3_dn;
    logic [DN_W-1:0]        n3_dn;

    // output stage
    logic                   r4_v;
    logic                   r4_ok;
    logic                   r4_leap;
    logic [DN_W-1:0]        r4_dn;
    logic [WD_W-1:0]        r4_wd;
    logic [MLEN_W-1:0]      r4_mlen;
    logic [WD_W-1:0]        n4_wd;

    assign advance      = !r4_v || o_res.ready;
    assign i_date.ready = advance;

    // january and february count as months 13 and 14 of the year before
    always_comb begin
        n1_early = (i_date.month <= MONTH_FEB);
        n1_ys    = n1_early ? YEAR_W'(i_date.year - 14'd1) : i_date.year;
        n1_ms    = n1_early ? MONTH_W'(i_date.month + MONTHS_YEAR) : i_date.month;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (advance) begin
            r1_v <= i_date.valid;
        end
        if (advance) begin
            r1_year  <= i_date.year;
            r1_month <= i_date.month;
            r1_day   <= i_date.day_of_month;
            r1_ys    <= n1_ys;
            r1_ms    <= n1_ms;
            r1_yq    <= PROD_W'(i_date.year) * PROD_W'(DIV100_MUL);
            r1_ysq   <= PROD_W'(n1_ys) * PROD_W'(DIV100_MUL);
        end
    end

    always_comb begin
        n2_qy   = r1_yq[DIV100_SHIFT +: CENT_W];
        n2_cent = r1_ysq[DIV100_SHIFT +: CENT_W];
        // multiple of 100 and of 400 via the quotient
        n2_leap = (r1_year[1:0] == 2'b00) &&
                  ((15'(n2_qy) * 15'd100 != 15'(r1_year)) || (n2_qy[1:0] == 2'b00));
        n2_mlen = month_days(r1_month, n2_leap);
        n2_ok   = (r1_year >= FIRST_YEAR) && (r1_year <= LAST_YEAR) &&
                  (r1_month >= MONTH_JAN) && (r1_month <= MONTH_DEC) &&
                  (r1_day != '0) && (MLEN_W'(r1_day) <= n2_mlen);
        n2_yoff  = YEAR_W'(r1_ys - BASE_YEAR);
        n2_yprod = 25'(n2_yoff) * 25'(DAYS_4Y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (advance) begin
            r2_v <= r1_v;
        end
        if (advance) begin
            r2_ok    <= n2_ok;
            r2_leap  <= n2_leap;
            r2_mlen  <= n2_mlen;
            r2_yterm <= n2_yprod[DN_W+1:2];
            r2_moff  <= month_offset(r1_ms);
            r2_day   <= r1_day;
            r2_corr  <= CENT_W'(n2_cent - (n2_cent >> 2));
        end
    end

    assign n3_dn = r2_yterm + DN_W'(r2_moff) + DN_W'(r2_day)
                 - DN_W'(r2_corr) - DAY_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (advance) begin
            r3_v <= r2_v;
        end
        if (advance) begin
            r3_ok   <= r2_ok;
            r3_leap <= r2_leap;
            r3_mlen <= r2_mlen;
            r3_dn   <= n3_dn;
        end
    end

    gdn_mod7 u_mod7 (
        .i_value (23'(r3_dn) + 23'd1),
        .o_rem   (n4_wd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (advance) begin
            r4_v <= r3_v;
        end
        if (advance) begin
            r4_ok   <= r3_ok;
            r4_leap <= r3_leap;
            r4_dn   <= r3_ok ? r3_dn : '0;
            r4_wd   <= r3_ok ? n4_wd : '0;
            r4_mlen <= r3_ok ? r3_mlen : '0;
        end
    end

    assign o_res.valid        = r4_v;
    assign o_res.valid_res    = r4_ok;
    assign o_res.leap         = r4_leap;
    assign o_res.day_number   = r4_dn;
    assign o_res.weekday      = r4_wd;
    assign o_res.month_length = r4_mlen;

endmodule
`default_nettype wire

@@ sim/gregorian_date_to_day_number_tb.sv @@
// testbench for gregorian_date_to_day_number: random and edge dates against a scoreboard
`timescale 1ns / 1ps
module gregorian_date_to_day_number_tb;
    import gdn_pkg::*;

    typedef struct packed {
        logic              valid_res;
        logic              leap;
        logic [DN_W-1:0]   day_number;
        logic [WD_W-1:0]   weekday;
        logic [MLEN_W-1:0] month_length;
    } t_day_result;

    class t_day_count_board;
        t_day_result due_days[$];
        int          errors = 0;

        static function bit leap_year(logic [YEAR_W-1:0] yr);
            return ((yr % 4) == 0 && (yr % 100) != 0) || ((yr % 400) == 0);
        endfunction

        static function int days_in(logic [MONTH_W-1:0] mo, bit lp);
            if (mo == MONTH_FEB) begin
                return lp ? 29 : 28;
            end
            if (mo == MONTH_APR || mo == MONTH_JUN || mo == MONTH_SEP || mo == MONTH_NOV) begin
                return 30;
            end
            return 31;
        endfunction

        function t_day_result date_to_days(logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo,
                                           logic [DAY_W-1:0] dd);
            t_day_result r;
            bit          ok;
            int          y, m, cent, corr, dn, mlen;
            r = '0;
            r.leap = leap_year(yr);
            ok = yr >= FIRST_YEAR && yr <= LAST_YEAR && mo >= MONTH_JAN && mo <= MONTH_DEC
                 && dd >= 1;
            mlen = days_in(mo, r.leap);
            if (ok && int'(dd) > mlen) begin
                ok = 0;
            end
            if (ok) begin
                y = int'(yr);
                m = int'(mo);
                // jan and feb count as months 13 and 14 of the year before
                if (m <= 2) begin
                    y = y - 1;
                    m = m + 12;
                end
                cent = y / 100;
                corr = cent - cent / 4;
                dn = (1461 * (y - int'(BASE_YEAR))) / 4 + (306 * (m + 1)) / 10 + int'(dd)
                     - corr - int'(DAY_OFFSET);
                r.valid_res    = 1'b1;
                r.day_number   = dn[DN_W-1:0];
                r.weekday      = 3'((dn + 1) % 7);
                r.month_length = mlen[MLEN_W-1:0];
            end
            return r;
        endfunction

        function void note_date(logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo,
                                logic [DAY_W-1:0] dd);
            due_days.push_back(date_to_days(yr, mo, dd));
        endfunction

        function void check_result(t_day_result got);
            t_day_result want;
            if (due_days.size() == 0) begin
                $error("result beat with nothing expected: %p", got);
                errors++;
                return;
            end
            want = due_days.pop_front();
            if (got.valid_res !== want.valid_res) begin
                $error("valid_res: expected %0d, actual %0d", want.valid_res, got.valid_res);
                errors++;
            end
            if (got.leap !== want.leap) begin
                $error("leap: expected %0d, actual %0d", want.leap, got.leap);
                errors++;
            end
            if (got.day_number !== want.day_number) begin
                $error("day_number: expected %0d, actual %0d", want.day_number, got.day_number);
                errors++;
            end
            if (got.weekday !== want.weekday) begin
                $error("weekday: expected %0d, actual %0d", want.weekday, got.weekday);
                errors++;
            end
            if (got.month_length !== want.month_length) begin
                $error("month_length: expected %0d, actual %0d", want.month_length,
                       got.month_length);
                errors++;
            end
        endfunction

        function int pending();
            return due_days.size();
        endfunction
    endclass

    localparam int RANDOM_DATES = 600;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 80;
    localparam int CALM_FROM    = 300;
    localparam int CALM_TO      = 420;
    localparam int DRAIN_AT     = 480;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gdn_in_if  date_if ();
    gdn_out_if res_if ();

    gregorian_date_to_day_number dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_date  (date_if),
        .o_res   (res_if)
    );

    t_day_count_board board = new();
    int               sent_count = 0;
    bit               calm;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    assign calm = sent_count >= CALM_FROM && sent_count < CALM_TO;

    task automatic send_date(logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo,
                             logic [DAY_W-1:0] dd);
        while (!calm && $urandom_range(0, 99) < 24) begin
            date_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        date_if.valid        <= 1'b1;
        date_if.year         <= yr;
        date_if.month        <= mo;
        date_if.day_of_month <= dd;
        do @(posedge i_clk); while (!(date_if.valid === 1'b1 && date_if.ready === 1'b1));
        board.note_date(yr, mo, dd);
        sent_count++;
    endtask

    // mostly real dates, some just past the month end, some raw noise
    task automatic send_random_date();
        logic [YEAR_W-1:0]  yr;
        logic [MONTH_W-1:0] mo;
        logic [DAY_W-1:0]   dd;
        int                 pick, mlen;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            yr = YEAR_W'($urandom_range(0, 16383));
            mo = MONTH_W'($urandom_range(0, 15));
            dd = DAY_W'($urandom_range(0, 31));
        end else begin
            case ($urandom_range(0, 5))
                0:       yr = YEAR_W'($urandom_range(1901, 1910));
                1:       yr = YEAR_W'($urandom_range(9990, 9999));
                2:       yr = YEAR_W'(100 * $urandom_range(20, 99));
                default: yr = YEAR_W'($urandom_range(1901, 9999));
            endcase
            mo = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
            mlen = t_day_count_board::days_in(mo, t_day_count_board::leap_year(yr));
            if (pick < 20) begin
                dd = DAY_W'($urandom_range(mlen + 1, 31));
            end else if (pick < 30) begin
                dd = DAY_W'(($urandom_range(0, 1) != 0) ? mlen : 1);
            end else begin
                dd = DAY_W'($urandom_range(1, mlen));
            end
        end
        send_date(yr, mo, dd);
    endtask

    // result side: checks each beat, stalls at random, one long hold-off
    initial begin
        bit held;
        int hold_left;
        held = 0;
        hold_left = 0;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                board.check_result({res_if.valid_res, res_if.leap, res_if.day_number,
                                    res_if.weekday, res_if.month_length});
            end
            if (!held && sent_count >= HOLD_AT) begin
                held = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= calm || $urandom_range(0, 99) >= 24;
            end
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        date_if.valid        <= 1'b0;
        date_if.year         <= '0;
        date_if.month        <= '0;
        date_if.day_of_month <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_date(14'd1901, MONTH_JAN, 5'd1);
        send_date(14'd9999, MONTH_DEC, 5'd31);
        send_date(14'd1900, MONTH_DEC, 5'd31);
        send_date(14'd10000, MONTH_JAN, 5'd1);
        send_date(14'd0, MONTH_FEB, 5'd29);
        send_date(14'd16383, 4'd15, 5'd31);
        send_date(14'd2000, MONTH_FEB, 5'd29);
        send_date(14'd2400, MONTH_FEB, 5'd29);
        send_date(14'd1904, MONTH_FEB, 5'd29);
        send_date(14'd1901, MONTH_FEB, 5'd29);
        // non-leap century: jan and feb use the shifted-year century
        send_date(14'd2100, MONTH_JAN, 5'd1);
        send_date(14'd2100, MONTH_FEB, 5'd28);
        send_date(14'd2100, MONTH_FEB, 5'd29);
        send_date(14'd2100, 4'd3, 5'd1);
        send_date(14'd2023, 4'd0, 5'd10);
        send_date(14'd2023, 4'd13, 5'd10);
        send_date(14'd2023, MONTH_JUN, 5'd0);
        send_date(14'd2023, MONTH_APR, 5'd31);
        send_date(14'd2023, MONTH_NOV, 5'd30);
        send_date(14'd2023, MONTH_SEP, 5'd31);
        send_date(14'd2023, 4'd7, 5'd31);
        send_date(14'd9999, MONTH_FEB, 5'd28);
        send_date(14'd8192, MONTH_JAN, 5'd31);

        for (int i = 0; i < RANDOM_DATES; i++) begin
            if (i == DRAIN_AT) begin
                date_if.valid <= 1'b0;
                do @(posedge i_clk); while (board.pending() != 0);
            end
            send_random_date();
        end
        date_if.valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
